// ----- sv/hsvl_pkg.sv -----
// shared types and constants for the hsv to rgb led colour block
`timescale 1ns / 1ps

package hsvl_pkg;

  // default full-scale channel level
  localparam int MAX_LEVEL_DEF = 255;

  // hue mod 360 via reciprocal: q = (hue * 2912) >> 20, low by at most one
  localparam logic [11:0] HUE_RECIP = 12'd2912;
  localparam int          HUE_SHIFT = 20;
  localparam logic [8:0]  HUE_MOD   = 9'd360;

  // vs / 120 via reciprocal: exact for all 16-bit vs
  localparam logic [17:0] SLOPE_RECIP = 18'd139811;
  localparam int          SLOPE_SHIFT = 24;

  // sector boundaries in degrees
  localparam logic [8:0] DEG_60  = 9'd60;
  localparam logic [8:0] DEG_120 = 9'd120;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_240 = 9'd240;
  localparam logic [8:0] DEG_300 = 9'd300;

  // 60-degree sectors of the hue circle
  localparam logic [2:0] SEC_RED     = 3'd0;
  localparam logic [2:0] SEC_YELLOW  = 3'd1;
  localparam logic [2:0] SEC_GREEN   = 3'd2;
  localparam logic [2:0] SEC_CYAN    = 3'd3;
  localparam logic [2:0] SEC_BLUE    = 3'd4;
  localparam logic [2:0] SEC_MAGENTA = 3'd5;

  typedef struct packed {
    logic [3:0]  led;
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsvl_in_t;

  typedef struct packed {
    logic [3:0]  led;
    logic [2:0]  sector;
    logic [5:0]  rel;
    logic [9:0]  slope;
    logic [15:0] top;
    logic [15:0] bottom;
    logic [15:0] half;
  } hsvl_lvl_t;

  typedef struct packed {
    logic [3:0]  led;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } hsvl_raw_t;

  typedef struct packed {
    logic [3:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsvl_px_t;

endpackage

// ----- sv/hsv_to_rgb_led_color_top.sv -----
// top level of the hsv to rgb led colour converter
`timescale 1ns / 1ps

// Converts an LED index with hue (degrees, any 16-bit value, taken mod 360),
// saturation and value into red, green and blue drive levels of 0..MAX_LEVEL,
// one word per clock while the output keeps taking them, with nothing carried
// between words. The six register stages are hue quotient, hue remainder and
// levels, sector split, ramp product, ramp routing and channel scaling. Each
// stage holds its own valid bit and moves on whenever the stage after it is
// empty or moving, so a stall at the output fills bubbles first and in_tready
// drops only once every stage holds a word.

module hsv_to_rgb_led_color_top #(
  parameter int MAX_LEVEL = hsvl_pkg::MAX_LEVEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // led_index[3:0], hue, saturation, value, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // led_out[3:0], red_level, green_level, blue_level
);

  hsvl_pkg::hsvl_in_t  in_word;
  hsvl_pkg::hsvl_lvl_t lvl;
  hsvl_pkg::hsvl_raw_t raw;
  hsvl_pkg::hsvl_px_t  px;
  logic lvl_valid, lvl_ready;
  logic raw_valid, raw_ready;

  assign in_word.led = in_tdata[3:0];
  assign in_word.hue = in_tdata[19:4];
  assign in_word.sat = in_tdata[27:20];
  assign in_word.val = in_tdata[35:28];

  hsvl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_tvalid),
    .i_ready (in_tready),
    .i_data  (in_word),
    .o_valid (lvl_valid),
    .o_ready (lvl_ready),
    .o_data  (lvl)
  );

  hsvl_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (lvl_valid),
    .i_ready (lvl_ready),
    .i_data  (lvl),
    .o_valid (raw_valid),
    .o_ready (raw_ready),
    .o_data  (raw)
  );

  hsvl_scale #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (raw_valid),
    .i_ready (raw_ready),
    .i_data  (raw),
    .o_valid (out_tvalid),
    .o_ready (out_tready),
    .o_data  (px)
  );

  assign out_tdata = {4'd0, px.blue, px.green, px.red, px.led};

endmodule

// ----- sv/hsvl_front.sv -----
// hue reduction, sector split and level/slope generation (three stages)
`timescale 1ns / 1ps

module hsvl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_ready,
  input  hsvl_pkg::hsvl_in_t  i_data,
  output logic                o_valid,
  input  logic                o_ready,
  output hsvl_pkg::hsvl_lvl_t o_data
);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  // stage 1: coarse quotient and val*sat
  logic [3:0]  led1_r;
  logic [15:0] hue1_r;
  logic [7:0]  val1_r;
  logic [7:0]  q1_r;
  logic [15:0] vs1_r;
  logic [27:0] hue_prod;
  logic [7:0]  q1_nxt;
  logic [15:0] vs1_nxt;

  // stage 2: reduced hue and levels
  logic [3:0]  led2_r;
  logic [8:0]  h2_r;
  logic [15:0] top2_r, bottom2_r, half2_r;
  logic [9:0]  slope2_r;
  logic [16:0] qx360;
  logic [16:0] rem;
  logic [9:0]  rem_lo;
  logic [9:0]  h_wide;
  logic [8:0]  h2_nxt;
  logic [15:0] top2_nxt;
  logic [33:0] slope_prod;

  // stage 3: sector and position within it
  hsvl_pkg::hsvl_lvl_t lvl3_r;
  hsvl_pkg::hsvl_lvl_t lvl3_nxt;
  logic [8:0]          base;

  assign adv3    = !v3_r || o_ready;
  assign adv2    = !v2_r || adv3;
  assign adv1    = !v1_r || adv2;
  assign i_ready = adv1;
  assign o_valid = v3_r;
  assign o_data  = lvl3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= i_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  assign hue_prod = i_data.hue * hsvl_pkg::HUE_RECIP;
  assign q1_nxt   = hue_prod[hsvl_pkg::HUE_SHIFT +: 8];
  assign vs1_nxt  = i_data.val * i_data.sat;

  always_ff @(posedge clk) begin
    if (adv1) begin
      led1_r <= i_data.led;
      hue1_r <= i_data.hue;
      val1_r <= i_data.val;
      q1_r   <= q1_nxt;
      vs1_r  <= vs1_nxt;
    end
  end

  // remainder lies in 0..719, one correction brings it below 360
  assign qx360      = q1_r * hsvl_pkg::HUE_MOD;
  assign rem        = {1'b0, hue1_r} - qx360;
  assign rem_lo     = rem[9:0];
  assign h_wide     = (rem_lo >= {1'b0, hsvl_pkg::HUE_MOD}) ?
                      (rem_lo - {1'b0, hsvl_pkg::HUE_MOD}) : rem_lo;
  assign h2_nxt     = h_wide[8:0];
  assign top2_nxt   = {val1_r, 8'd0} - {8'd0, val1_r};
  assign slope_prod = vs1_r * hsvl_pkg::SLOPE_RECIP;

  always_ff @(posedge clk) begin
    if (adv2) begin
      led2_r    <= led1_r;
      h2_r      <= h2_nxt;
      top2_r    <= top2_nxt;
      bottom2_r <= top2_nxt - vs1_r;
      half2_r   <= {1'b0, vs1_r[15:1]};
      slope2_r  <= slope_prod[hsvl_pkg::SLOPE_SHIFT +: 10];
    end
  end

  always_comb begin
    lvl3_nxt        = '0;
    lvl3_nxt.led    = led2_r;
    lvl3_nxt.slope  = slope2_r;
    lvl3_nxt.top    = top2_r;
    lvl3_nxt.bottom = bottom2_r;
    lvl3_nxt.half   = half2_r;
    if (h2_r >= hsvl_pkg::DEG_300) begin
      lvl3_nxt.sector = hsvl_pkg::SEC_MAGENTA;
      base            = hsvl_pkg::DEG_300;
    end else if (h2_r >= hsvl_pkg::DEG_240) begin
      lvl3_nxt.sector = hsvl_pkg::SEC_BLUE;
      base            = hsvl_pkg::DEG_240;
    end else if (h2_r >= hsvl_pkg::DEG_180) begin
      lvl3_nxt.sector = hsvl_pkg::SEC_CYAN;
      base            = hsvl_pkg::DEG_180;
    end else if (h2_r >= hsvl_pkg::DEG_120) begin
      lvl3_nxt.sector = hsvl_pkg::SEC_GREEN;
      base            = hsvl_pkg::DEG_120;
    end else if (h2_r >= hsvl_pkg::DEG_60) begin
      lvl3_nxt.sector = hsvl_pkg::SEC_YELLOW;
      base            = hsvl_pkg::DEG_60;
    end else begin
      lvl3_nxt.sector = hsvl_pkg::SEC_RED;
      base            = 9'd0;
    end
    lvl3_nxt.rel = 6'(h2_r - base);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      lvl3_r <= lvl3_nxt;
    end
  end

endmodule

// ----- sv/hsvl_mix.sv -----
// ramp generation and per-sector channel routing (two stages)
`timescale 1ns / 1ps

module hsvl_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_ready,
  input  hsvl_pkg::hsvl_lvl_t i_data,
  output logic                o_valid,
  input  logic                o_ready,
  output hsvl_pkg::hsvl_raw_t o_data
);

  logic v4_r, v5_r;
  logic adv4, adv5;

  logic [3:0]  led4_r;
  logic [2:0]  sec4_r;
  logic [15:0] top4_r, bottom4_r, half4_r, run4_r;
  logic [15:0] run4_nxt;

  logic [15:0] ra, rb, rc, rd;
  hsvl_pkg::hsvl_raw_t raw5_r;
  hsvl_pkg::hsvl_raw_t raw5_nxt;

  assign adv5    = !v5_r || o_ready;
  assign adv4    = !v4_r || adv5;
  assign i_ready = adv4;
  assign o_valid = v5_r;
  assign o_data  = raw5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv4) v4_r <= i_valid;
      if (adv5) v5_r <= v4_r;
    end
  end

  assign run4_nxt = i_data.slope * i_data.rel;

  always_ff @(posedge clk) begin
    if (adv4) begin
      led4_r    <= i_data.led;
      sec4_r    <= i_data.sector;
      top4_r    <= i_data.top;
      bottom4_r <= i_data.bottom;
      half4_r   <= i_data.half;
      run4_r    <= run4_nxt;
    end
  end

  // rising and falling ramps, 16-bit wrap
  assign ra = bottom4_r + run4_r;
  assign rb = bottom4_r + half4_r + run4_r;
  assign rc = top4_r - run4_r;
  assign rd = top4_r - half4_r - run4_r;

  always_comb begin
    raw5_nxt     = '0;
    raw5_nxt.led = led4_r;
    case (sec4_r)
      hsvl_pkg::SEC_RED: begin
        raw5_nxt.red = rc;        raw5_nxt.green = ra;        raw5_nxt.blue = bottom4_r;
      end
      hsvl_pkg::SEC_YELLOW: begin
        raw5_nxt.red = rd;        raw5_nxt.green = rb;        raw5_nxt.blue = bottom4_r;
      end
      hsvl_pkg::SEC_GREEN: begin
        raw5_nxt.red = bottom4_r; raw5_nxt.green = rc;        raw5_nxt.blue = ra;
      end
      hsvl_pkg::SEC_CYAN: begin
        raw5_nxt.red = bottom4_r; raw5_nxt.green = rd;        raw5_nxt.blue = rb;
      end
      hsvl_pkg::SEC_BLUE: begin
        raw5_nxt.red = ra;        raw5_nxt.green = bottom4_r; raw5_nxt.blue = rc;
      end
      default: begin
        raw5_nxt.red = rb;        raw5_nxt.green = bottom4_r; raw5_nxt.blue = rd;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      raw5_r <= raw5_nxt;
    end
  end

endmodule

// ----- sv/hsvl_scale.sv -----
// divides each channel by 65535/MAX_LEVEL through a reciprocal multiply
`timescale 1ns / 1ps

module hsvl_scale #(
  parameter int MAX_LEVEL = hsvl_pkg::MAX_LEVEL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_ready,
  input  hsvl_pkg::hsvl_raw_t i_data,
  output logic                o_valid,
  input  logic                o_ready,
  output hsvl_pkg::hsvl_px_t  o_data
);

  localparam int SCALE_RAW = 65535 / MAX_LEVEL;
  localparam int SCALE     = (SCALE_RAW == 0) ? 1 : SCALE_RAW;
  localparam int SHIFT     = 16 + $clog2(SCALE);
  localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT) + 64'(SCALE) - 64'd1) / 64'(SCALE);
  localparam logic [17:0] RECIP   = RECIP_W[17:0];

  logic v6_r;
  logic adv6;

  logic [33:0] pr_r, pr_g, pr_b;
  logic [33:0] sh_r, sh_g, sh_b;
  hsvl_pkg::hsvl_px_t px6_r;
  hsvl_pkg::hsvl_px_t px6_nxt;

  assign adv6    = !v6_r || o_ready;
  assign i_ready = adv6;
  assign o_valid = v6_r;
  assign o_data  = px6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv6) begin
      v6_r <= i_valid;
    end
  end

  assign pr_r = i_data.red   * RECIP;
  assign pr_g = i_data.green * RECIP;
  assign pr_b = i_data.blue  * RECIP;
  assign sh_r = pr_r >> SHIFT;
  assign sh_g = pr_g >> SHIFT;
  assign sh_b = pr_b >> SHIFT;

  always_comb begin
    px6_nxt.led   = i_data.led;
    px6_nxt.red   = sh_r[7:0];
    px6_nxt.green = sh_g[7:0];
    px6_nxt.blue  = sh_b[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv6) begin
      px6_r <= px6_nxt;
    end
  end

endmodule

// ----- bench/hsv_to_rgb_led_color_top_test.sv -----
// testbench for the hsv to rgb led colour converter with self-checking predictor
`timescale 1ns / 1ps

module hsv_to_rgb_led_color_top_test;

  localparam int          LEVEL_MAX   = hsvl_pkg::MAX_LEVEL_DEF;
  localparam logic [15:0] CHAN_SCALE  = 16'hFFFF / LEVEL_MAX;
  localparam logic [15:0] FULL_SCALE  = 16'd255;
  localparam logic [15:0] SLOPE_DIV   = 16'd120;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 12;
  localparam int          MAX_REPORTS = 10;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // led_index[3:0], hue, saturation, value, zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // led_out[3:0], red_level, green_level, blue_level

  hsvl_pkg::hsvl_px_t pixels_due[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       hold_len = 0;

  hsv_to_rgb_led_color_top #(
    .MAX_LEVEL(LEVEL_MAX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pixels_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // expected colour for one input word, all ramps kept to 16 bits
  function automatic hsvl_pkg::hsvl_px_t predict_pixel(hsvl_pkg::hsvl_in_t w);
    logic [15:0] deg, rel, top, bottom, vs, slope, run, half;
    logic [15:0] ra, rb, rc, rd, r, g, b;
    logic [2:0]  sector;
    hsvl_pkg::hsvl_px_t px;
    deg    = w.hue % 16'(hsvl_pkg::HUE_MOD);
    sector = 3'(deg / 16'(hsvl_pkg::DEG_60));
    rel    = deg - 16'(sector) * 16'(hsvl_pkg::DEG_60);
    top    = 16'(w.val) * FULL_SCALE;
    bottom = 16'(w.val) * (FULL_SCALE - 16'(w.sat));
    vs     = 16'(w.val) * 16'(w.sat);
    slope  = vs / SLOPE_DIV;
    run    = slope * rel;
    half   = vs >> 1;
    ra     = bottom + run;
    rb     = bottom + half + run;
    rc     = top - run;
    rd     = top - half - run;
    case (sector)
      hsvl_pkg::SEC_RED:    begin r = rc;     g = ra;     b = bottom; end
      hsvl_pkg::SEC_YELLOW: begin r = rd;     g = rb;     b = bottom; end
      hsvl_pkg::SEC_GREEN:  begin r = bottom; g = rc;     b = ra;     end
      hsvl_pkg::SEC_CYAN:   begin r = bottom; g = rd;     b = rb;     end
      hsvl_pkg::SEC_BLUE:   begin r = ra;     g = bottom; b = rc;     end
      default:              begin r = rb;     g = bottom; b = rd;     end
    endcase
    px.led   = w.led;
    px.red   = 8'(r / CHAN_SCALE);
    px.green = 8'(g / CHAN_SCALE);
    px.blue  = 8'(b / CHAN_SCALE);
    return px;
  endfunction

  function automatic hsvl_pkg::hsvl_in_t make_word(int led, int hue, int sat, int val);
    hsvl_pkg::hsvl_in_t w;
    w.led = 4'(led);
    w.hue = 16'(hue);
    w.sat = 8'(sat);
    w.val = 8'(val);
    return w;
  endfunction

  // saturation and value lean towards their extremes now and then
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic hsvl_pkg::hsvl_in_t random_word(bit wide_hue);
    hsvl_pkg::hsvl_in_t w;
    w.led = 4'($urandom_range(0, 15));
    w.hue = wide_hue ? 16'($urandom) : 16'($urandom_range(0, 719));
    w.sat = pick_level();
    w.val = pick_level();
    return w;
  endfunction

  task automatic send_word(input hsvl_pkg::hsvl_in_t w);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, w.val, w.sat, w.hue, w.led};
    do @(posedge clk); while (!in_tready);
    pixels_due.push_back(predict_pixel(w));
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 40'({$urandom, $urandom});
    end
  endtask

  task automatic wait_drained();
    wait (pixels_due.size() == 0);
  endtask

  // bursts of random length, gaps between them, with spells of no gaps
  task automatic send_random(int count, bit wide_hue);
    int burst_left;
    int gap_max;
    burst_left = 0;
    gap_max = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(0, 3) == 0) gap_max = $urandom_range(0, 1) ? 0 : 9;
        if (gap_max > 0) idle_for($urandom_range(1, gap_max));
      end
      send_word(random_word(wide_hue));
      burst_left--;
    end
  endtask

  task automatic test_sector_edges();
    int starts[6] = '{0, 60, 120, 180, 240, 300};
    foreach (starts[i]) begin
      send_word(make_word(i, starts[i], 255, 255));
      send_word(make_word(i + 6, starts[i] + 59, 255, 255));
    end
  endtask

  task automatic test_grey_and_dark();
    send_word(make_word(0, 200, 0, 255));
    send_word(make_word(11, 30, 255, 0));
    send_word(make_word(15, 90, 0, 0));
    send_word(make_word(12, 330, 1, 1));
    send_word(make_word(5, 150, 128, 200));
  endtask

  task automatic test_hue_wrap();
    send_word(make_word(3, 360, 255, 255));
    send_word(make_word(9, 65535, 255, 255));
    send_word(make_word(14, 719, 200, 180));
    send_word(make_word(1, 720, 37, 254));
    send_random(200, 1'b1);
  endtask

  task automatic test_random_stream();
    send_random(800, 1'b0);
  endtask

  // long output hold while words keep coming, so the pipe fills and stalls
  task automatic test_backpressure();
    idle_for(1);
    wait_drained();
    hold_len = 80;
    for (int i = 0; i < 60; i++) send_word(random_word(i[0]));
  endtask

  task automatic test_drain_pause();
    send_random(40, 1'b0);
    idle_for(1);
    wait_drained();
    idle_for($urandom_range(5, 30));
    send_random(40, 1'b1);
  endtask

  // receiver switches between its own stall patterns, or obeys a hold request
  initial begin : rx_stall
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    out_tready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_tready <= ($urandom_range(0, 9) != 0);
          default:   out_tready <= (phase % 5 < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_px
    hsvl_pkg::hsvl_px_t got;
    hsvl_pkg::hsvl_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.led   = out_tdata[3:0];
      got.red   = out_tdata[11:4];
      got.green = out_tdata[19:12];
      got.blue  = out_tdata[27:20];
      if (pixels_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected word: led %0d r %0d g %0d b %0d", got.led, got.red,
                   got.green, got.blue);
      end else begin
        want = pixels_due.pop_front();
        if (got.led !== want.led || got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: led %0d/%0d r %0d/%0d g %0d/%0d b %0d/%0d (exp/got)",
                     want.led, got.led, want.red, got.red, want.green, got.green,
                     want.blue, got.blue);
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sector_edges();
    test_grey_and_dark();
    test_hue_wrap();
    test_random_stream();
    test_backpressure();
    test_drain_pause();

    idle_for(1);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
